// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the checker files.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, ignored while reset is high.
`define ASSERT_AT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/sss_pkg.sv -----
// Shared types and fixed widths for the sample set statistics block.
// No dependencies; imported by every module of the block.
`default_nettype none

package sss_pkg;

   localparam int SAMPLE_W = 24;
   localparam int COUNT_W  = 16;
   localparam int SUM_W    = 40;
   localparam int SQ_W     = 64;
   localparam int MEAN_W   = 32;
   localparam int VAR_W    = 56;
   localparam int DEV_W    = 32;
   localparam int DIFF_W   = 80;  // n*Q - S*S
   localparam int NN_W     = 32;  // n*n
   localparam int QUO_W    = 64;
   localparam int DIV_W    = 96;  // DIFF_W plus room for two fraction shifts

   typedef struct packed {
      logic [SAMPLE_W-1:0] sample;
      logic                has_sample;
      logic                last;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0]  count;
      logic [SUM_W-1:0]    total;
      logic [MEAN_W-1:0]   mean_fx;
      logic [VAR_W-1:0]    variance_fx;
      logic [DEV_W-1:0]    deviation_fx;
      logic [SAMPLE_W-1:0] minimum;
      logic [SAMPLE_W-1:0] maximum;
      logic                overflowed;
   } rsp_type;

   // Accumulator snapshot of one closed set
   typedef struct packed {
      logic [COUNT_W-1:0]  count;
      logic [SUM_W-1:0]    sum;
      logic [SQ_W-1:0]     sq_sum;
      logic [SAMPLE_W-1:0] min_val;
      logic [SAMPLE_W-1:0] max_val;
      logic                drop;
   } snap_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

// ----- rtl/sss_front.sv -----
// Front end: accepts samples and accumulates count, sum, sum of squares, min, max.
// Depends on sss_pkg; pushes a snapshot into the set queue on each closing item.
`default_nettype none

module sss_front #(
   parameter int SAMPLE_BITS = 24,
   parameter int COUNT_BITS  = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_ready,
   input  wire sss_pkg::req_type          req_data,
   input  wire sss_pkg::queue_status_type q_status,
   output logic                           push_valid,
   output sss_pkg::snap_type              push_data
);
   import sss_pkg::*;

   localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((1 << SAMPLE_BITS) - 1);
   localparam logic [COUNT_W-1:0]  COUNT_MAX   = COUNT_W'((1 << COUNT_BITS) - 1);

   logic [COUNT_W-1:0]    cnt_ff, cnt_in;
   logic [SUM_W-1:0]      sum_ff, sum_in;
   logic [SQ_W-1:0]       sq_ff, sq_in;
   logic [SAMPLE_W-1:0]   min_ff, min_in;
   logic [SAMPLE_W-1:0]   max_ff, max_in;
   logic                  drop_ff, drop_in;
   logic [SAMPLE_W-1:0]   smp;
   logic [2*SAMPLE_W-1:0] sq_term;
   logic                  accept;
   logic                  at_limit;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;
   assign smp       = req_data.sample & SAMPLE_MASK;
   assign sq_term   = (2*SAMPLE_W)'(smp) * (2*SAMPLE_W)'(smp);
   assign at_limit  = (cnt_ff == COUNT_MAX);

   always_comb begin
      cnt_in  = cnt_ff;
      sum_in  = sum_ff;
      sq_in   = sq_ff;
      min_in  = min_ff;
      max_in  = max_ff;
      drop_in = drop_ff;
      if (accept && req_data.has_sample) begin
         if (!at_limit) begin
            cnt_in = cnt_ff + COUNT_W'(1);
            sum_in = sum_ff + SUM_W'(smp);
            sq_in  = sq_ff + SQ_W'(sq_term);
            if (smp < min_ff) begin
               min_in = smp;
            end
            if (smp > max_ff) begin
               max_in = smp;
            end
         end else begin
            drop_in = 1'b1;
         end
      end
   end

   // Sample and close together: the snapshot already holds the new sample
   assign push_valid = accept && req_data.last;
   assign push_data  = '{count: cnt_in, sum: sum_in, sq_sum: sq_in,
                         min_val: min_in, max_val: max_in, drop: drop_in};

   always_ff @(posedge clock) begin
      if (reset || push_valid) begin
         cnt_ff  <= '0;
         sum_ff  <= '0;
         sq_ff   <= '0;
         min_ff  <= SAMPLE_MASK;
         max_ff  <= '0;
         drop_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         sum_ff  <= sum_in;
         sq_ff   <= sq_in;
         min_ff  <= min_in;
         max_ff  <= max_in;
         drop_ff <= drop_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/sss_queue.sv -----
// Two-entry queue of closed-set snapshots between front and back end.
// Depends on sss_pkg for the snapshot and status types.
`default_nettype none

module sss_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push_valid,
   input  wire sss_pkg::snap_type    push_data,
   input  wire logic                 pop,
   output sss_pkg::snap_type         pop_data,
   output sss_pkg::queue_status_type q_status
);
   import sss_pkg::*;

   localparam int DEPTH  = 2;
   localparam int PTR_W  = $clog2(DEPTH);
   localparam int FILL_W = $clog2(DEPTH + 1);

   snap_type          entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [FILL_W-1:0] fill_ff;
   logic              do_push;
   logic              do_pop;

   assign q_status.full  = (fill_ff == FILL_W'(DEPTH));
   assign q_status.empty = (fill_ff == '0);
   assign do_push        = push_valid && !q_status.full;
   assign do_pop         = pop && !q_status.empty;
   assign pop_data       = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + FILL_W'(1);
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - FILL_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/sss_back.sv -----
// Back end: turns one closed-set snapshot into mean, variance and deviation.
// Depends on sss_pkg; shares one restoring divider, a digit multiplier and a root unit.
`default_nettype none

module sss_back #(
   parameter int FRAC_BITS = 8
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire sss_pkg::queue_status_type q_status,
   output logic                           pop,
   input  wire sss_pkg::snap_type         pop_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output sss_pkg::rsp_type               rsp_data
);
   import sss_pkg::*;

   localparam int Q_DIG_W   = 16;
   localparam int S_DIG_W   = 8;
   localparam int Q_DIGITS  = SQ_W / Q_DIG_W;
   localparam int S_DIGITS  = SUM_W / S_DIG_W;
   localparam int MUL_STEPS = Q_DIGITS + S_DIGITS;
   localparam int MEAN_STEPS = SUM_W + FRAC_BITS;
   localparam int VAR_STEPS  = DIFF_W + 2*FRAC_BITS;
   localparam int CNT_W     = $clog2(VAR_STEPS + 1);
   localparam int QIDX_W    = $clog2(Q_DIGITS);
   localparam int SIDX_W    = $clog2(S_DIGITS);
   localparam int SHIFT_W   = $clog2(DIFF_W);
   localparam int PROD_W    = SUM_W + Q_DIG_W;

   localparam logic [CNT_W-1:0] MEAN_CNT = CNT_W'(MEAN_STEPS);
   localparam logic [CNT_W-1:0] VAR_CNT  = CNT_W'(VAR_STEPS);
   localparam logic [CNT_W-1:0] VAR_TAP  = CNT_W'(FRAC_BITS + 1);
   localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(MUL_STEPS);
   localparam logic [CNT_W-1:0] Q_END    = CNT_W'(Q_DIGITS);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MEAN,
      ST_MUL,
      ST_VAR,
      ST_ROOT,
      ST_DONE
   } state_type;

   state_type            state_ff;
   logic [COUNT_W-1:0]   n_ff;
   logic [SUM_W-1:0]     sum_ff;
   logic [SQ_W-1:0]      sq_ff;
   logic [SAMPLE_W-1:0]  min_ff;
   logic [SAMPLE_W-1:0]  max_ff;
   logic                 drop_ff;
   logic [MEAN_W-1:0]    mean_ff;
   logic [VAR_W-1:0]     var_ff;
   logic [DEV_W-1:0]     dev_ff;
   logic [NN_W-1:0]      nn_ff;
   logic [CNT_W-1:0]     cnt_ff;
   logic [DIFF_W-1:0]    prod_ff;
   logic                 prod_sub_ff;
   logic [DIFF_W-1:0]    acc_ff;
   logic [DIV_W-1:0]     dvd_ff;
   logic [NN_W-1:0]      divisor_ff;
   logic [NN_W-1:0]      rem_ff;
   logic [QUO_W-1:0]     quo_ff;
   logic [QUO_W-1:0]     root_x_ff;
   logic [QUO_W-1:0]     root_res_ff;
   logic [QUO_W-1:0]     root_bit_ff;
   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;

   // Restoring divider step: one quotient bit per cycle
   logic [NN_W:0]        div_trial;
   logic                 div_ge;
   logic [NN_W-1:0]      div_rem;
   logic [QUO_W-1:0]     div_quo;

   assign div_trial = {rem_ff, dvd_ff[DIV_W-1]};
   assign div_ge    = (div_trial >= {1'b0, divisor_ff});
   assign div_rem   = div_ge ? NN_W'(div_trial - {1'b0, divisor_ff}) : NN_W'(div_trial);
   assign div_quo   = {quo_ff[QUO_W-2:0], div_ge};

   // Digit multiplier for n*Q - S*S
   logic [QIDX_W-1:0]    q_idx;
   logic [SIDX_W-1:0]    s_idx;
   logic [SUM_W-1:0]     mul_a;
   logic [Q_DIG_W-1:0]   mul_b;
   logic [SHIFT_W-1:0]   mul_shift;
   logic [PROD_W-1:0]    mul_p;
   logic [DIFF_W-1:0]    prod_in;
   logic [DIFF_W-1:0]    acc_in;

   assign q_idx = cnt_ff[QIDX_W-1:0];
   assign s_idx = SIDX_W'(cnt_ff - Q_END);

   always_comb begin
      mul_a     = '0;
      mul_b     = '0;
      mul_shift = '0;
      priority if (cnt_ff < Q_END) begin
         mul_a     = SUM_W'(n_ff);
         mul_b     = sq_ff[q_idx*Q_DIG_W +: Q_DIG_W];
         mul_shift = SHIFT_W'(q_idx) << $clog2(Q_DIG_W);
      end else if (cnt_ff < MUL_LAST) begin
         mul_a     = sum_ff;
         mul_b     = Q_DIG_W'(sum_ff[s_idx*S_DIG_W +: S_DIG_W]);
         mul_shift = SHIFT_W'(s_idx) << $clog2(S_DIG_W);
      end else begin
         mul_a     = '0;
      end
   end

   assign mul_p   = PROD_W'(mul_a) * PROD_W'(mul_b);
   assign prod_in = DIFF_W'(mul_p) << mul_shift;
   assign acc_in  = prod_sub_ff ? acc_ff - prod_ff : acc_ff + prod_ff;

   // Integer square root, two radicand bits per cycle
   logic [QUO_W-1:0]     root_t;
   logic                 root_ge;
   logic [QUO_W-1:0]     root_res_in;

   assign root_t      = root_res_ff + root_bit_ff;
   assign root_ge     = (root_x_ff >= root_t);
   assign root_res_in = root_ge ? (root_res_ff >> 1) + root_bit_ff : root_res_ff >> 1;

   assign pop       = (state_ff == ST_IDLE) && !q_status.empty;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && (state_ff != ST_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (!q_status.empty) begin
                  n_ff       <= pop_data.count;
                  sum_ff     <= pop_data.sum;
                  sq_ff      <= pop_data.sq_sum;
                  min_ff     <= pop_data.min_val;
                  max_ff     <= pop_data.max_val;
                  drop_ff    <= pop_data.drop;
                  mean_ff    <= '0;
                  var_ff     <= '0;
                  dev_ff     <= '0;
                  divisor_ff <= NN_W'(pop_data.count);
                  dvd_ff     <= {pop_data.sum, {(DIV_W-SUM_W){1'b0}}};
                  rem_ff     <= '0;
                  quo_ff     <= '0;
                  cnt_ff     <= MEAN_CNT;
                  state_ff   <= (pop_data.count == '0) ? ST_DONE : ST_MEAN;
               end
            end
            ST_MEAN: begin
               rem_ff <= div_rem;
               quo_ff <= div_quo;
               dvd_ff <= dvd_ff << 1;
               if (cnt_ff == CNT_W'(1)) begin
                  mean_ff     <= MEAN_W'(div_quo);
                  nn_ff       <= NN_W'(n_ff) * NN_W'(n_ff);
                  acc_ff      <= '0;
                  prod_sub_ff <= 1'b0;
                  cnt_ff      <= '0;
                  state_ff    <= (n_ff < COUNT_W'(2)) ? ST_DONE : ST_MUL;
               end else begin
                  cnt_ff <= cnt_ff - CNT_W'(1);
               end
            end
            ST_MUL: begin
               // Product of this step lands in prod_ff; the previous one is summed
               prod_ff     <= prod_in;
               prod_sub_ff <= (cnt_ff >= Q_END);
               if (cnt_ff != '0) begin
                  acc_ff <= acc_in;
               end
               if (cnt_ff == MUL_LAST) begin
                  dvd_ff     <= {acc_in, {(DIV_W-DIFF_W){1'b0}}};
                  divisor_ff <= nn_ff;
                  rem_ff     <= '0;
                  quo_ff     <= '0;
                  cnt_ff     <= VAR_CNT;
                  state_ff   <= ST_VAR;
               end else begin
                  cnt_ff <= cnt_ff + CNT_W'(1);
               end
            end
            ST_VAR: begin
               rem_ff <= div_rem;
               quo_ff <= div_quo;
               dvd_ff <= dvd_ff << 1;
               cnt_ff <= cnt_ff - CNT_W'(1);
               // FRAC_BITS quotient bits short of the end: the variance
               if (cnt_ff == VAR_TAP) begin
                  var_ff <= VAR_W'(div_quo);
               end
               if (cnt_ff == CNT_W'(1)) begin
                  root_x_ff   <= div_quo;
                  root_res_ff <= '0;
                  root_bit_ff <= QUO_W'(1) << (QUO_W - 2);
                  state_ff    <= ST_ROOT;
               end
            end
            ST_ROOT: begin
               if (root_ge) begin
                  root_x_ff <= root_x_ff - root_t;
               end
               root_res_ff <= root_res_in;
               root_bit_ff <= root_bit_ff >> 2;
               if (root_bit_ff[0]) begin
                  dev_ff   <= DEV_W'(root_res_in);
                  state_ff <= ST_DONE;
               end
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_ff.count        <= n_ff;
                  rsp_ff.total        <= sum_ff;
                  rsp_ff.mean_fx      <= mean_ff;
                  rsp_ff.variance_fx  <= var_ff;
                  rsp_ff.deviation_fx <= dev_ff;
                  rsp_ff.minimum      <= (n_ff == '0) ? '0 : min_ff;
                  rsp_ff.maximum      <= (n_ff == '0) ? '0 : max_ff;
                  rsp_ff.overflowed   <= drop_ff;
                  rsp_valid_ff        <= 1'b1;
                  state_ff            <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- rtl/sample_set_statistics.sv -----
// Work per set: no arithmetic for an empty set, the mean division for a single sample, and
//   n*Q - S*S, the variance division and the root for larger sets. Throughput: one sample
//   transaction per cycle unless the queue is full; closed sets are finished one at a time,
//   each bound by the shared bit-serial divider (mean, then variance) and the root unit.
// Reset: synchronous, active high; accumulators take their empty-set values, queue empties.
`default_nettype none

module sample_set_statistics #(
   parameter int SAMPLE_BITS = 24,
   parameter int COUNT_BITS  = 16,
   parameter int FRAC_BITS   = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire sss_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output sss_pkg::rsp_type      rsp_data
);
   import sss_pkg::*;

   // Front end to queue: snapshot of a set as it closes
   logic             push_valid;
   snap_type         push_data;

   // Queue to back end
   logic             pop;
   snap_type         pop_data;
   queue_status_type q_status;

   // Accumulate samples at full rate; stall only when both queue slots hold closed sets
   sss_front #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .COUNT_BITS  (COUNT_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .q_status   (q_status),
      .push_valid (push_valid),
      .push_data  (push_data)
   );

   // Hold closed sets so new samples keep flowing while the back end divides
   sss_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .pop        (pop),
      .pop_data   (pop_data),
      .q_status   (q_status)
   );

   // Sequence mean division, n*Q - S*S, variance division and square root;
   // the result sits in an output register until taken
   sss_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .pop       (pop),
      .pop_data  (pop_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ----- rtl/sss_checker.sv -----
// Port-level checks for sample_set_statistics, bound to the top level.
// Depends on sss_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module sss_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire sss_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire sss_pkg::rsp_type rsp_data
);
   import sss_pkg::*;

   logic stalled;
   logic empty_rsp;
   logic empty_zero;
   logic small_rsp;
   logic small_zero;
   logic filled_rsp;
   logic ordered;

   assign stalled    = rsp_valid && !rsp_ready;
   assign empty_rsp  = rsp_valid && (rsp_data.count == '0);
   assign empty_zero = (rsp_data.total == '0) && (rsp_data.mean_fx == '0)
                       && (rsp_data.minimum == '0) && (rsp_data.maximum == '0)
                       && !rsp_data.overflowed;
   assign small_rsp  = rsp_valid && (rsp_data.count < COUNT_W'(2));
   assign small_zero = (rsp_data.variance_fx == '0) && (rsp_data.deviation_fx == '0);
   assign filled_rsp = rsp_valid && (rsp_data.count != '0);
   assign ordered    = (rsp_data.minimum <= rsp_data.maximum);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, stalled, rsp_valid && $stable(rsp_data), "result moved")

   `ASSERT_AT(a_empty_zero, clock, reset, empty_rsp |-> empty_zero, "empty set result not zero")

   `ASSERT_AT(a_small_var, clock, reset, small_rsp |-> small_zero, "spread not zero")

   `ASSERT_AT(a_min_max, clock, reset, filled_rsp |-> ordered, "minimum above maximum")

endmodule

bind sample_set_statistics sss_checker u_sss_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
